FILE: sv/lrupr_pkg.sv
package lrupr_pkg;

  localparam int CAPACITY  = 16;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int WAYS_W    = 5;
  localparam int PAGE_W    = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 32;

  typedef logic [CAPACITY-1:0]  slot_vec_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } lrupr_state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic commit;
  } lrupr_cmd_t;

  function automatic slot_vec_t lowest_set(input slot_vec_t v);
    lowest_set = v & (~v + slot_vec_t'(1));
  endfunction

  function automatic slot_idx_t onehot_to_idx(input slot_vec_t v);
    slot_idx_t idx;
    idx = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (v[k]) begin
        idx = idx | slot_idx_t'(k);
      end
    end
    onehot_to_idx = idx;
  endfunction

endpackage

FILE: sv/lrupr_ctrl.sv
module lrupr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output lrupr_pkg::lrupr_cmd_t cmd
);
  import lrupr_pkg::*;

  lrupr_state_t state;
  lrupr_state_t state_next;
  logic         accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

  always_comb begin
    busy       = (state == ST_LOOKUP);
    accept     = start && !busy;
    cmd.load   = accept;
    cmd.decide = 1'b0;
    cmd.commit = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.decide = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/lrupr_datapath.sv
module lrupr_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  lrupr_pkg::lrupr_cmd_t   cmd,
  input  logic                    cfg_write,
  input  logic [lrupr_pkg::WAYS_W-1:0] cfg_data,
  input  logic [lrupr_pkg::PAGE_W-1:0] page_number,
  output logic                    hit,
  output logic [lrupr_pkg::IDX_W-1:0]  slot_index,
  output logic                    replaced_valid,
  output logic [lrupr_pkg::PAGE_W-1:0] replaced_page,
  output logic [lrupr_pkg::CNT_W-1:0]  fault_count
);
  import lrupr_pkg::*;

  page_t               slot_page [CAPACITY];
  slot_vec_t           slot_valid;
  slot_idx_t           rank      [CAPACITY];
  logic [CNT_W-1:0]    faults;
  logic [CNT_W-1:0]    faults_next;
  logic [WAYS_W-1:0]   ways;
  logic [WAYS_W-1:0]   ways_eff;

  page_t               page_q;
  logic                hit_q;
  logic                repl_q;
  slot_idx_t           slot_q;
  page_t               repl_page_q;

  slot_vec_t           active;
  slot_vec_t           match;
  slot_vec_t           free;
  slot_vec_t           lru;
  slot_vec_t           sel_vec;
  slot_idx_t           sel_idx;
  slot_idx_t           old_rank;

  always_comb begin
    priority if (ways == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (ways > WAYS_W'(CAPACITY)) begin
      ways_eff = WAYS_W'(CAPACITY);
    end else begin
      ways_eff = ways;
    end
  end

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      active[k] = WAYS_W'(k) < ways_eff;
      match[k]  = active[k] && slot_valid[k] && (slot_page[k] == page_q);
      free[k]   = active[k] && !slot_valid[k];
    end
    for (int k = 0; k < CAPACITY; k++) begin
      lru[k] = active[k];
      for (int j = 0; j < CAPACITY; j++) begin
        if (active[j] && (rank[j] < rank[k])) lru[k] = 1'b0;
      end
    end
    priority if (|match) begin
      sel_vec = lowest_set(match);
    end else if (|free) begin
      sel_vec = lowest_set(free);
    end else begin
      sel_vec = lowest_set(lru);
    end
    sel_idx = onehot_to_idx(sel_vec);
  end

  assign old_rank    = rank[slot_q];
  assign faults_next = (hit_q || (faults == '1)) ? faults : faults + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      faults     <= '0;
      ways       <= WAYS_W'(CAPACITY);
      for (int k = 0; k < CAPACITY; k++) begin
        rank[k] <= SLOT_W'(k);
      end
    end else begin
      if (cfg_write) ways <= cfg_data;
      if (cmd.commit) begin
        faults             <= faults_next;
        slot_valid[slot_q] <= 1'b1;
        for (int k = 0; k < CAPACITY; k++) begin
          if (rank[k] > old_rank) rank[k] <= rank[k] - SLOT_W'(1);
        end
        rank[slot_q] <= SLOT_W'(CAPACITY - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) page_q <= page_number[PAGE_BITS-1:0];
    if (cmd.decide) begin
      hit_q       <= |match;
      repl_q      <= !(|match) && !(|free);
      slot_q      <= sel_idx;
      repl_page_q <= slot_page[sel_idx];
    end
    if (cmd.commit) begin
      if (!hit_q) slot_page[slot_q] <= page_q;
      hit            <= hit_q;
      slot_index     <= IDX_W'(slot_q);
      replaced_valid <= repl_q;
      replaced_page  <= repl_q ? PAGE_W'(repl_page_q) : '0;
      fault_count    <= faults_next;
    end
  end

endmodule

FILE: sv/lru_page_replacement_core.sv
// Fully associative LRU page replacement over 16 slots.
// The result strobe (done) is registered from the commit state after lookup.
// A new word is accepted in the commit state of the previous word, but not in
// the lookup state, where busy is high. Results cannot be stalled.
// Reset (rst, synchronous): slots empty, ranks by index, fault total zero,
// ways_in_use at 16; ready for a word in the cycle after reset.
module lru_page_replacement_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] page_number,
  output logic        done,
  output logic        hit,
  output logic [3:0]  slot_index,
  output logic        replaced_valid,
  output logic [15:0] replaced_page,
  output logic [31:0] fault_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import lrupr_pkg::*;

  lrupr_cmd_t cmd;

  assign cfg_ready = 1'b1;

  lrupr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  lrupr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .page_number    (page_number),
    .hit            (hit),
    .slot_index     (slot_index),
    .replaced_valid (replaced_valid),
    .replaced_page  (replaced_page),
    .fault_count    (fault_count)
  );

endmodule

FILE: tb/sv/lru_page_replacement_core_tb.sv
`timescale 1ns / 1ps
module lru_page_replacement_core_tb;
  import lrupr_pkg::*;

  localparam int RUN_LIMIT    = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_SIZE    = 24;
  localparam int PHASES       = 14;
  localparam int PHASE_WORDS  = 138;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  slot;
    logic              evicted;
    logic [PAGE_W-1:0] victim;
    logic [CNT_W-1:0]  faults;
  } page_outcome_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [PAGE_W-1:0] page_number;
  logic              done;
  logic              hit;
  logic [IDX_W-1:0]  slot_index;
  logic              replaced_valid;
  logic [PAGE_W-1:0] replaced_page;
  logic [CNT_W-1:0]  fault_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [WAYS_W-1:0] cfg_data;

  logic [PAGE_W-1:0] held_page [CAPACITY];
  bit                held_valid [CAPACITY];
  int                recency [CAPACITY];
  logic [CNT_W-1:0]  fault_total;
  logic [WAYS_W-1:0] ways_reg;

  page_outcome_t     pending_outcomes [$];
  logic [PAGE_W-1:0] page_pool [POOL_SIZE];
  int                mismatches  = 0;
  int                cycle_count = 0;
  bit                gapless     = 0;

  lru_page_replacement_core DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .page_number    (page_number),
    .done           (done),
    .hit            (hit),
    .slot_index     (slot_index),
    .replaced_valid (replaced_valid),
    .replaced_page  (replaced_page),
    .fault_count    (fault_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("lru_page_replacement_core_tb: FAIL");
      $finish;
    end
  end

  function automatic int effective_ways();
    if (ways_reg == '0) return 1;
    if (ways_reg > WAYS_W'(CAPACITY)) return CAPACITY;
    return int'(ways_reg);
  endfunction

  function automatic page_outcome_t lru_reference(input logic [PAGE_W-1:0] page);
    page_outcome_t o;
    int            ways;
    int            sel;
    int            old_rank;
    bit            found;
    bit            free_found;
    ways       = effective_ways();
    o          = '0;
    sel        = 0;
    found      = 1'b0;
    free_found = 1'b0;
    for (int k = 0; k < ways; k++) begin
      if (!found && held_valid[k] && held_page[k] == page) begin
        sel   = k;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int k = 0; k < ways; k++) begin
        if (!free_found && !held_valid[k]) begin
          sel        = k;
          free_found = 1'b1;
        end
      end
      if (!free_found) begin
        sel = 0;
        for (int k = 1; k < ways; k++) begin
          if (recency[k] < recency[sel]) sel = k;
        end
        o.evicted = 1'b1;
        o.victim  = held_page[sel];
      end
      held_page[sel]  = page;
      held_valid[sel] = 1'b1;
      if (fault_total != '1) fault_total = fault_total + CNT_W'(1);
    end
    old_rank = recency[sel];
    for (int k = 0; k < CAPACITY; k++) begin
      if (recency[k] > old_rank) recency[k] = recency[k] - 1;
    end
    recency[sel] = CAPACITY - 1;
    o.hit    = found;
    o.slot   = sel[IDX_W-1:0];
    o.faults = fault_total;
    return o;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %0h want %0h", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    page_outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected word", {31'd0, done}, 32'd0);
      end else begin
        want = pending_outcomes.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (slot_index !== want.slot)
          report_mismatch("slot_index", 32'(slot_index), 32'(want.slot));
        if (replaced_valid !== want.evicted)
          report_mismatch("replaced_valid", 32'(replaced_valid), 32'(want.evicted));
        if (replaced_page !== want.victim)
          report_mismatch("replaced_page", 32'(replaced_page), 32'(want.victim));
        if (fault_count !== want.faults)
          report_mismatch("fault_count", fault_count, want.faults);
      end
    end
  end

  task automatic send_word(input logic [PAGE_W-1:0] page);
    start       = 1'b1;
    page_number = page;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(lru_reference(page));
    @(negedge clk);
    start       = 1'b0;
    page_number = PAGE_W'($urandom);
  endtask

  task automatic idle_gap();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (gapless || roll < 55) n = 0;
    else if (roll < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_ways(input logic [WAYS_W-1:0] value);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    ways_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_fill_and_hit();
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0000);
    idle_gap();
    send_word(16'hFFFF);
    send_word(16'h1234);
    send_word(16'h8001);
  endtask

  task automatic test_way_limits();
    write_ways(5'd0);
    send_word(16'hA5A5);
    send_word(16'h5A5A);
    send_word(16'h5A5A);
    send_word(16'hFFFF);
    write_ways(5'd17);
    send_word(16'h1234);
    send_word(16'h8001);
    write_ways(5'd2);
    send_word(16'h7FFE);
    send_word(16'hC3C3);
  endtask

  task automatic test_duplicate_copies();
    write_ways(5'd31);
    send_word(16'hBEEF);
    write_ways(5'd1);
    send_word(16'hBEEF);
    write_ways(5'd16);
    send_word(16'hBEEF);
    send_word(16'h1234);
  endtask

  task automatic test_random_traffic();
    int pool_used;
    for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = PAGE_W'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_ways(5'd16);
        1:       write_ways(5'd1);
        2:       write_ways(5'd4);
        3:       write_ways(5'd0);
        4:       write_ways(5'd31);
        5:       write_ways(5'd8);
        6:       write_ways(5'd2);
        7:       write_ways(5'd16);
        default: write_ways(WAYS_W'($urandom_range(0, 31)));
      endcase
      repeat ($urandom_range(0, 8)) begin
        page_pool[$urandom_range(0, POOL_SIZE - 1)] = PAGE_W'($urandom);
      end
      pool_used = effective_ways() + $urandom_range(0, 6);
      if (pool_used > POOL_SIZE) pool_used = POOL_SIZE;
      gapless = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < 15) send_word(PAGE_W'($urandom));
        else send_word(page_pool[$urandom_range(0, pool_used - 1)]);
        if ($urandom_range(0, 199) == 0) wait_idle();
        else idle_gap();
      end
    end
    gapless = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    page_number = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      held_page[k]  = '0;
      held_valid[k] = 1'b0;
      recency[k]    = k;
    end
    fault_total = '0;
    ways_reg    = WAYS_W'(CAPACITY);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_fill_and_hit();
    test_way_limits();
    test_duplicate_copies();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("lru_page_replacement_core_tb: PASS");
    end else begin
      $display("lru_page_replacement_core_tb: FAIL");
    end
    $finish;
  end

endmodule
